FILE: rtl/core/bbrl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbrl_pkg
// shared types and constants of the block base rank lookup
// ----------------------------------------------------------------------------
package bbrl_pkg;

  localparam int ADDR_W     = 64;
  localparam int TPB_W      = 16;
  localparam int TLEN_W     = 16;
  localparam int LIM_W      = TPB_W + TLEN_W;
  localparam int IDX_W      = 22;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_TPB  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TLEN = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOFOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_DUP     = 2'd3;

  typedef logic [ADDR_W-1:0] addr_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_SEL,
    S_MUL
  } state_t;

  typedef struct packed {
    logic found;
    logic dup;
    logic full;
  } srch_flags_t;

endpackage
`default_nettype wire

FILE: rtl/core/bbrl_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbrl_cell
// one slot of the sorted base row: holds a base, compares it with the key
// and shifts in its lower neighbor's base, or takes the key, on an insert
// ----------------------------------------------------------------------------
module bbrl_cell (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cmp_en,
  input  wire logic          ins_en,
  input  wire bbrl_pkg::addr_t key,
  input  wire bbrl_pkg::addr_t prev_base,
  input  wire logic          prev_valid,
  input  wire logic          prev_gt,
  output bbrl_pkg::addr_t    base,
  output logic               valid,
  output logic               le,
  output logic               eq
);
  import bbrl_pkg::*;

  addr_t base_r;
  logic  valid_r;
  logic  le_r;
  logic  eq_r;
  logic  gt;

  assign gt = ~le_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      le_r    <= 1'b0;
      eq_r    <= 1'b0;
    end else begin
      if (cmp_en) begin
        le_r <= valid_r & (base_r <= key);
        eq_r <= valid_r & (base_r == key);
      end
      if (ins_en && gt) begin
        valid_r <= valid_r | prev_valid;
      end
    end
  end

  // payload shift, no reset
  always_ff @(posedge clk) begin
    if (ins_en && gt) begin
      base_r <= prev_gt ? prev_base : key;
    end
  end

  assign base  = base_r;
  assign valid = valid_r;
  assign le    = le_r;
  assign eq    = eq_r;

endmodule
`default_nettype wire

FILE: rtl/core/bbrl_chain.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbrl_chain
// row of base cells kept in ascending order, with boundary detection
// that yields the predecessor's rank and base
// ----------------------------------------------------------------------------
module bbrl_chain #(
  parameter int N  = 64,
  parameter int RW = 6
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cmp_en,
  input  wire logic              ins_en,
  input  wire bbrl_pkg::addr_t   key,
  output logic [RW-1:0]          rank,
  output bbrl_pkg::addr_t        best,
  output bbrl_pkg::srch_flags_t  flags
);
  import bbrl_pkg::*;

  addr_t        base_q [N];
  logic [N-1:0] valid_q;
  logic [N-1:0] le_q;
  logic [N-1:0] eq_q;
  logic [N-1:0] bnd;

  genvar g;
  generate
    for (g = 0; g < N; g++) begin : g_cell
      if (g == 0) begin : g_first
        bbrl_cell u_cell (
          .clk        (clk),
          .rst_n      (rst_n),
          .cmp_en     (cmp_en),
          .ins_en     (ins_en),
          .key        (key),
          .prev_base  (key),
          .prev_valid (1'b1),
          .prev_gt    (1'b0),
          .base       (base_q[g]),
          .valid      (valid_q[g]),
          .le         (le_q[g]),
          .eq         (eq_q[g])
        );
      end else begin : g_next
        bbrl_cell u_cell (
          .clk        (clk),
          .rst_n      (rst_n),
          .cmp_en     (cmp_en),
          .ins_en     (ins_en),
          .key        (key),
          .prev_base  (base_q[g-1]),
          .prev_valid (valid_q[g-1]),
          .prev_gt    (~le_q[g-1]),
          .base       (base_q[g]),
          .valid      (valid_q[g]),
          .le         (le_q[g]),
          .eq         (eq_q[g])
        );
      end
      if (g == N - 1) begin : g_last_bnd
        assign bnd[g] = le_q[g];
      end else begin : g_mid_bnd
        assign bnd[g] = le_q[g] & ~le_q[g+1];
      end
    end
  endgenerate

  always_comb begin
    rank = '0;
    best = '0;
    for (int i = 0; i < N; i++) begin
      if (bnd[i]) begin
        rank = rank | RW'(i);
        best = best | base_q[i];
      end
    end
  end

  assign flags.found = le_q[0];
  assign flags.dup   = |eq_q;
  assign flags.full  = valid_q[N-1];

endmodule
`default_nettype wire

FILE: rtl/core/block_base_rank_lookup.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// block_base_rank_lookup
// predecessor lookup over a sorted row of storage block bases
// ----------------------------------------------------------------------------
// Each transaction passes through compare in every cell, boundary select and
// rank multiply while busy is high after start is taken. The result strobe
// follows, and the next start may already be taken in that cycle, so a new
// transaction waits for the previous one's result strobe. out_valid is high
// for exactly one cycle per transaction and cannot be held off. Bases are kept
// in ascending order in a row of MAX_BLOCKS cells; a load shifts the larger
// bases up by one cell. The config registers may be written only while busy
// is low and no result is pending.
// ----------------------------------------------------------------------------
module block_base_rank_lookup #(
  parameter int MAX_BLOCKS = 64
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic                               in_req_type,
  input  wire logic [bbrl_pkg::ADDR_W-1:0]        in_block_address,
  input  wire logic [bbrl_pkg::ADDR_W-1:0]        in_tuple_address,
  output logic                                    out_valid,
  output logic [bbrl_pkg::IDX_W-1:0]              out_first_tuple_index,
  output logic [bbrl_pkg::STATUS_W-1:0]           out_status,
  input  wire logic                               cfg_we,
  input  wire logic [bbrl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [bbrl_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import bbrl_pkg::*;

  localparam int RW     = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int PROD_W = RW + TPB_W;

  state_t state_r, state_nxt;

  logic                req_r;
  addr_t               key_r;
  logic [TPB_W-1:0]    tpb_r;
  logic [TLEN_W-1:0]   tlen_r;
  logic [TLEN_W-1:0]   tlen_eff;
  logic [LIM_W-1:0]    lim_r;
  logic [RW-1:0]       rank_r;
  addr_t               best_r;
  logic                found_r;
  logic                dup_r;
  logic                full_r;
  logic                hit_r;
  logic                cache_valid_r;
  addr_t               cached_base_r;
  logic [IDX_W-1:0]    cached_index_r;
  logic                out_valid_r;
  logic [IDX_W-1:0]    out_idx_r;
  logic [STATUS_W-1:0] out_status_r;

  logic          accept;
  logic          cmp_en;
  logic          ins_en;
  logic [RW-1:0] rank;
  addr_t         best;
  srch_flags_t   flags;
  logic [ADDR_W:0]   diff;
  logic              hit;
  logic [PROD_W-1:0] prod;
  logic [IDX_W-1:0]  idx_calc;

  assign accept = start & ~busy;

  // fsm next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (start) state_nxt = S_CMP;
      S_CMP:  state_nxt = S_SEL;
      S_SEL:  state_nxt = S_MUL;
      S_MUL:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // fsm outputs
  always_comb begin
    busy   = 1'b1;
    cmp_en = 1'b0;
    unique case (state_r)
      S_IDLE: busy = 1'b0;
      S_CMP:  cmp_en = 1'b1;
      S_SEL:  busy = 1'b1;
      S_MUL:  busy = 1'b1;
      default: busy = 1'b1;
    endcase
  end

  assign ins_en = (state_r == S_SEL) & (req_r == REQ_LOAD) & ~flags.full & ~flags.dup;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // config registers and cache range limit
  assign tlen_eff = (tlen_r == '0) ? TLEN_W'(1) : tlen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tpb_r  <= TPB_W'(1);
      tlen_r <= TLEN_W'(1);
      lim_r  <= LIM_W'(1);
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_TPB:  tpb_r  <= cfg_wdata;
          CFG_TLEN: tlen_r <= cfg_wdata;
          default:  tpb_r  <= tpb_r;
        endcase
      end
      lim_r <= LIM_W'(tpb_r) * LIM_W'(tlen_eff);
    end
  end

  // transaction capture
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_req_type;
      key_r <= (in_req_type == REQ_LOOKUP) ? in_tuple_address : in_block_address;
    end
  end

  bbrl_chain #(
    .N  (MAX_BLOCKS),
    .RW (RW)
  ) u_chain (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmp_en (cmp_en),
    .ins_en (ins_en),
    .key    (key_r),
    .rank   (rank),
    .best   (best),
    .flags  (flags)
  );

  // cache range check
  assign diff = {1'b0, key_r} - {1'b0, cached_base_r};
  assign hit  = cache_valid_r & ~diff[ADDR_W] & (diff[ADDR_W-1:0] < ADDR_W'(lim_r));

  always_ff @(posedge clk) begin
    if (state_r == S_SEL) begin
      rank_r  <= rank;
      best_r  <= best;
      found_r <= flags.found;
      dup_r   <= flags.dup;
      full_r  <= flags.full;
      hit_r   <= hit;
    end
  end

  assign prod     = PROD_W'(rank_r) * PROD_W'(tpb_r);
  assign idx_calc = IDX_W'(prod);

  // cache and result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cache_valid_r  <= 1'b0;
      cached_base_r  <= '0;
      cached_index_r <= '0;
      out_valid_r    <= 1'b0;
      out_idx_r      <= '0;
      out_status_r   <= ST_OK;
    end else begin
      out_valid_r <= 1'b0;
      if (ins_en) begin
        cache_valid_r <= 1'b0;
      end
      if (state_r == S_MUL) begin
        out_valid_r <= 1'b1;
        if (req_r == REQ_LOOKUP) begin
          if (hit_r) begin
            out_idx_r    <= cached_index_r;
            out_status_r <= ST_OK;
          end else if (found_r) begin
            out_idx_r      <= idx_calc;
            out_status_r   <= ST_OK;
            cache_valid_r  <= 1'b1;
            cached_base_r  <= best_r;
            cached_index_r <= idx_calc;
          end else begin
            out_idx_r    <= '0;
            out_status_r <= ST_NOFOUND;
          end
        end else begin
          out_idx_r <= '0;
          if (full_r) begin
            out_status_r <= ST_FULL;
          end else if (dup_r) begin
            out_status_r <= ST_DUP;
          end else begin
            out_status_r <= ST_OK;
          end
        end
      end
    end
  end

  assign out_valid             = out_valid_r;
  assign out_first_tuple_index = out_idx_r;
  assign out_status            = out_status_r;

  // checks
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##4 out_valid)
    else $error("transaction result missing");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_nofound_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_NOFOUND || out_status == ST_FULL
                   || out_status == ST_DUP)) |-> (out_first_tuple_index == '0))
    else $error("nonzero index on failed transaction");

  a_load_clears_cache: assert property (@(posedge clk) disable iff (!rst_n)
    ins_en |=> !cache_valid_r)
    else $error("cache still valid after insert");

endmodule
`default_nettype wire
